### sv/pdq_pkg.sv
package pdq_pkg;

  typedef enum logic [2:0] {
    CMD_INS_FRONT  = 3'd0,
    CMD_INS_REAR   = 3'd1,
    CMD_REM_FRONT  = 3'd2,
    CMD_REM_REAR   = 3'd3,
    CMD_PEEK_FRONT = 3'd4,
    CMD_PEEK_REAR  = 3'd5,
    CMD_CLEAR      = 3'd6
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_BAD_DIST = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

endpackage

### sv/pdq_ram.sv
module pdq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

### sv/positional_deque_top.sv
// steps: a command is accepted in idle and checked; clear and every error status go
// straight to done; peek reads its word; insert moves each word behind the insert point
// up one place, then writes the new word; remove reads its word, then moves each word
// behind it down one place. one transaction at a time; each moved word is read, then written.
// reset (rst_ni low, asynchronous) empties the queue; stored words are left as they are.
module positional_deque_top
  import pdq_pkg::*;
#(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [2:0]            command_i,
  input  logic [DATA_WIDTH-1:0] item_word_i,
  input  logic [CW-1:0]         distance_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [DATA_WIDTH-1:0] result_word_o,
  output logic [1:0]            status_o,
  output logic [CW-1:0]         occupancy_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_GRAB,
    S_INS_RD,
    S_INS_WR,
    S_INS_PUT,
    S_REM_RD,
    S_REM_WR,
    S_DONE
  } state_e;

  state_e                state_q;
  logic [2:0]            cmd_q;
  logic [DATA_WIDTH-1:0] word_q;
  logic [CW-1:0]         dist_q;
  logic [CW-1:0]         count_q;
  logic [AW-1:0]         pos_q;
  logic [AW-1:0]         idx_q;
  status_e               status_q;
  logic [DATA_WIDTH-1:0] res_q;
  logic                  out_valid_q;
  logic [DATA_WIDTH-1:0] out_word_q;
  status_e               out_status_q;
  logic [CW-1:0]         out_occ_q;

  status_e               chk_status;
  logic [CW-1:0]         chk_pos;
  logic                  is_rem;

  logic                  ram_wr_en;
  logic [AW-1:0]         ram_wr_addr;
  logic [DATA_WIDTH-1:0] ram_wr_data;
  logic                  ram_rd_en;
  logic [AW-1:0]         ram_rd_addr;
  logic [DATA_WIDTH-1:0] ram_rd_data;

  assign is_rem = (cmd_q == CMD_REM_FRONT) || (cmd_q == CMD_REM_REAR);

  // status and target position of the latched command
  always_comb begin
    chk_status = ST_OK;
    chk_pos    = '0;
    case (cmd_q) inside
      CMD_INS_FRONT, CMD_INS_REAR: begin
        if (count_q == CW'(DEPTH)) begin
          chk_status = ST_FULL;
        end else if (dist_q > count_q) begin
          chk_status = ST_BAD_DIST;
        end else begin
          chk_pos = (cmd_q == CMD_INS_FRONT) ? dist_q : count_q - dist_q;
        end
      end
      CMD_REM_FRONT, CMD_REM_REAR, CMD_PEEK_FRONT, CMD_PEEK_REAR: begin
        if (count_q == '0) begin
          chk_status = ST_EMPTY;
        end else if (dist_q >= count_q) begin
          chk_status = ST_BAD_DIST;
        end else if ((cmd_q == CMD_REM_FRONT) || (cmd_q == CMD_PEEK_FRONT)) begin
          chk_pos = dist_q;
        end else begin
          chk_pos = count_q - CW'(1) - dist_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    ram_wr_en   = 1'b0;
    ram_wr_addr = idx_q;
    ram_wr_data = ram_rd_data;
    ram_rd_en   = 1'b0;
    ram_rd_addr = idx_q;
    case (state_q)
      S_CHECK: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = chk_pos[AW-1:0];
      end
      S_INS_RD: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = idx_q - AW'(1);
      end
      S_INS_WR, S_REM_WR: begin
        ram_wr_en = 1'b1;
      end
      S_INS_PUT: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = pos_q;
        ram_wr_data = word_q;
      end
      S_REM_RD: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = idx_q + AW'(1);
      end
      default: begin
      end
    endcase
  end

  pdq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_pdq_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_wr_en),
    .wr_addr_i (ram_wr_addr),
    .wr_data_i (ram_wr_data),
    .rd_en_i   (ram_rd_en),
    .rd_addr_i (ram_rd_addr),
    .rd_data_o (ram_rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cmd_q        <= '0;
      word_q       <= '0;
      dist_q       <= '0;
      count_q      <= '0;
      pos_q        <= '0;
      idx_q        <= '0;
      status_q     <= ST_OK;
      res_q        <= '0;
      out_valid_q  <= 1'b0;
      out_word_q   <= '0;
      out_status_q <= ST_OK;
      out_occ_q    <= '0;
    end else begin
      if (out_valid_q && out_ready_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            cmd_q   <= command_i;
            word_q  <= item_word_i;
            dist_q  <= distance_i;
            state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          status_q <= chk_status;
          res_q    <= '0;
          pos_q    <= chk_pos[AW-1:0];
          if (chk_status != ST_OK) begin
            state_q <= S_DONE;
          end else begin
            case (cmd_q) inside
              CMD_INS_FRONT, CMD_INS_REAR: begin
                idx_q   <= count_q[AW-1:0];
                state_q <= (count_q == chk_pos) ? S_INS_PUT : S_INS_RD;
              end
              CMD_REM_FRONT, CMD_REM_REAR, CMD_PEEK_FRONT, CMD_PEEK_REAR: begin
                state_q <= S_GRAB;
              end
              CMD_CLEAR: begin
                count_q <= '0;
                state_q <= S_DONE;
              end
              default: begin
                state_q <= S_DONE;
              end
            endcase
          end
        end
        S_GRAB: begin
          res_q <= ram_rd_data;
          idx_q <= pos_q;
          if (!is_rem) begin
            state_q <= S_DONE;
          end else if (CW'(pos_q) + CW'(1) < count_q) begin
            state_q <= S_REM_RD;
          end else begin
            count_q <= count_q - CW'(1);
            state_q <= S_DONE;
          end
        end
        S_INS_RD: begin
          state_q <= S_INS_WR;
        end
        // word at idx-1 moves up to idx
        S_INS_WR: begin
          idx_q   <= idx_q - AW'(1);
          state_q <= (idx_q - AW'(1) == pos_q) ? S_INS_PUT : S_INS_RD;
        end
        S_INS_PUT: begin
          count_q <= count_q + CW'(1);
          state_q <= S_DONE;
        end
        S_REM_RD: begin
          state_q <= S_REM_WR;
        end
        // word at idx+1 moves down to idx
        S_REM_WR: begin
          idx_q <= idx_q + AW'(1);
          if (CW'(idx_q) + CW'(2) < count_q) begin
            state_q <= S_REM_RD;
          end else begin
            count_q <= count_q - CW'(1);
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q  <= 1'b1;
            out_word_q   <= res_q;
            out_status_q <= status_q;
            out_occ_q    <= count_q;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign result_word_o = out_word_q;
  assign status_o      = out_status_q;
  assign occupancy_o   = out_occ_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("occupancy above depth");

  a_full_means_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q == ST_FULL) |-> out_occ_q == CW'(DEPTH))
    else $error("full status with free room");

  a_word_zero_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q != ST_OK) |-> out_word_q == '0)
    else $error("result word set on failed transaction");

  a_shift_above_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INS_RD || state_q == S_INS_WR) |-> idx_q > pos_q)
    else $error("insert shift went below the gap");

  a_remove_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_REM_WR && !(CW'(idx_q) + CW'(2) < count_q))
      |=> count_q == $past(count_q) - CW'(1))
    else $error("remove did not drop occupancy");
`endif

endmodule

### sim/tb.sv
module tb;
  import pdq_pkg::*;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned RUN_LIMIT = 400000;
  localparam int unsigned SETTLE_CYCLES = 48;
  localparam logic [2:0] CMD_UNUSED = 3'd7;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] word;
    logic [4:0]  offs;
  } deque_cmd_t;

  typedef struct packed {
    logic [31:0] word;
    status_e     status;
    logic [4:0]  occ;
  } deque_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [2:0]  command_i;
  logic [31:0] item_word_i;
  logic [4:0]  distance_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [31:0] result_word_o;
  logic [1:0]  status_o;
  logic [4:0]  occupancy_o;

  deque_cmd_t    pending_cmds[$];
  deque_result_t expected_results[$];
  logic [31:0]   plan_words[$];
  logic [31:0]   held_words[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned errors = 0;
  int unsigned cycle_count = 0;
  logic        in_acc = 1'b0;
  bit          fill_bias = 1'b1;

  positional_deque_top u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .command_i    (command_i),
    .item_word_i  (item_word_i),
    .distance_i   (distance_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .result_word_o(result_word_o),
    .status_o     (status_o),
    .occupancy_o  (occupancy_o)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // applies one command to a word list, position 0 is the front
  function automatic deque_result_t deque_apply(ref logic [31:0] words[$], input deque_cmd_t c);
    deque_result_t r;
    int unsigned cnt;
    int unsigned pos;
    cnt = words.size();
    r.word = '0;
    r.status = ST_OK;
    case (c.cmd)
      CMD_INS_FRONT, CMD_INS_REAR: begin
        if (cnt >= DEPTH) r.status = ST_FULL;
        else if (c.offs > cnt) r.status = ST_BAD_DIST;
        else begin
          pos = (c.cmd == CMD_INS_FRONT) ? c.offs : cnt - c.offs;
          words.insert(pos, c.word);
        end
      end
      CMD_REM_FRONT, CMD_REM_REAR, CMD_PEEK_FRONT, CMD_PEEK_REAR: begin
        if (cnt == 0) r.status = ST_EMPTY;
        else if (c.offs >= cnt) r.status = ST_BAD_DIST;
        else begin
          pos = (c.cmd == CMD_REM_FRONT || c.cmd == CMD_PEEK_FRONT) ? c.offs
                                                                      : cnt - 1 - c.offs;
          r.word = words[pos];
          if (c.cmd == CMD_REM_FRONT || c.cmd == CMD_REM_REAR) words.delete(pos);
        end
      end
      CMD_CLEAR: words.delete();
      default: ;
    endcase
    r.occ = 5'(words.size());
    return r;
  endfunction

  // plan_words tracks the queue as the stimulus will leave it
  task automatic queue_cmd(input logic [2:0] c, input logic [31:0] w, input logic [4:0] d);
    deque_cmd_t it;
    it.cmd = c;
    it.word = w;
    it.offs = d;
    void'(deque_apply(plan_words, it));
    pending_cmds.push_back(it);
  endtask

  task automatic gen_random(input int unsigned n);
    int unsigned cnt;
    int unsigned pick;
    logic [2:0]  c;
    logic [31:0] w;
    logic [4:0]  d;
    for (int unsigned i = 0; i < n; i++) begin
      cnt = plan_words.size();
      if ($urandom_range(99) < 4) fill_bias = !fill_bias;
      pick = $urandom_range(99);
      if (pick < 1) c = CMD_CLEAR;
      else if (pick < 3) c = CMD_UNUSED;
      else if (pick < (fill_bias ? 65 : 30)) c = $urandom_range(1) ? CMD_INS_FRONT : CMD_INS_REAR;
      else c = 3'($urandom_range(5, 2));
      pick = $urandom_range(9);
      if (pick == 0) w = '0;
      else if (pick == 1) w = '1;
      else w = $urandom;
      // mostly legal distances so transactions reach deep positions
      if ($urandom_range(99) < 15) d = 5'($urandom_range(31));
      else if (c == CMD_INS_FRONT || c == CMD_INS_REAR) d = 5'($urandom_range(cnt));
      else d = (cnt == 0) ? 5'd0 : 5'($urandom_range(cnt - 1));
      queue_cmd(c, w, d);
    end
  endtask

  task automatic drain();
    while (pending_cmds.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(posedge clk_i);
  endtask

  // driver
  always @(negedge clk_i) begin : drv
    deque_cmd_t it;
    if (rst_ni && !(in_valid_i && !in_acc)) begin
      if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        it = pending_cmds.pop_front();
        command_i   <= it.cmd;
        item_word_i <= it.word;
        distance_i  <= it.offs;
        in_valid_i  <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // monitor: check results first, then predict the newly accepted transaction
  always @(posedge clk_i) begin : mon
    deque_result_t want;
    deque_cmd_t    got;
    in_acc <= in_valid_i && in_ready_o;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result word=%h status=%0d occ=%0d",
                   $time, result_word_o, status_o, occupancy_o);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (result_word_o !== want.word) begin
            $display("%0t: result_word expected %h actual %h", $time, want.word, result_word_o);
            errors++;
          end
          if (status_o !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, status_o);
            errors++;
          end
          if (occupancy_o !== want.occ) begin
            $display("%0t: occupancy expected %0d actual %0d", $time, want.occ, occupancy_o);
            errors++;
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        got.cmd = command_i;
        got.word = item_word_i;
        got.offs = distance_i;
        expected_results.push_back(deque_apply(held_words, got));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    out_ready_i = 1'b0;
    command_i   = '0;
    item_word_i = '0;
    distance_i  = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // empty-queue errors and the unused code, then inserts, peeks and a fill to full
    queue_cmd(CMD_PEEK_FRONT, 32'h0, 5'd0);
    queue_cmd(CMD_REM_REAR, 32'h0, 5'd0);
    queue_cmd(CMD_INS_FRONT, 32'h1234_5678, 5'd1);
    queue_cmd(CMD_UNUSED, 32'hffff_ffff, 5'd31);
    queue_cmd(CMD_INS_FRONT, 32'h0000_0000, 5'd0);
    queue_cmd(CMD_INS_REAR, 32'hffff_ffff, 5'd0);
    queue_cmd(CMD_INS_FRONT, 32'ha5a5_a5a5, 5'd2);
    queue_cmd(CMD_INS_REAR, 32'h5a5a_5a5a, 5'd3);
    queue_cmd(CMD_PEEK_FRONT, 32'h0, 5'd3);
    queue_cmd(CMD_PEEK_REAR, 32'h0, 5'd0);
    queue_cmd(CMD_PEEK_REAR, 32'h0, 5'd4);
    for (int unsigned i = 0; i < 12; i++)
      queue_cmd(i[0] ? CMD_INS_REAR : CMD_INS_FRONT, $urandom, 5'($urandom_range(4 + i)));
    // full is reported ahead of a bad distance
    queue_cmd(CMD_INS_REAR, 32'hdead_beef, 5'd31);
    // front removal at the last position takes the rear word
    queue_cmd(CMD_REM_FRONT, 32'h0, 5'd15);
    queue_cmd(CMD_REM_REAR, 32'h0, 5'd2);
    queue_cmd(CMD_CLEAR, 32'h0, 5'd0);
    drain();

    gen_random(300);
    drain();
    send_idle_pct = 86;
    gen_random(220);
    drain();
    send_idle_pct = 0;
    recv_stall_pct = 86;
    gen_random(220);
    drain();
    send_idle_pct = 7;
    recv_stall_pct = 7;
    gen_random(210);
    drain();

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, expected_results.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
